// ===== hw/rtl/flash_region_table_assert.svh =====
// Assertion macros shared by the flash region table design.
`ifndef FLASH_REGION_TABLE_ASSERT_SVH
`define FLASH_REGION_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FRT_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FRT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/frt_pkg.sv =====
`timescale 1ns / 1ps
package frt_pkg;

	localparam int MAX_REGIONS = 16;
	localparam int CNT_W = $clog2(MAX_REGIONS + 1);
	localparam logic [32:0] LIMIT_RESET = 33'h1000000;
	localparam int LABEL_MAX = 15;

	typedef enum logic [2:0] {
		OP_CLEAR = 3'd0,
		OP_ADD = 3'd1,
		OP_FIND_ADDR = 3'd2,
		OP_FIND_KIND = 3'd3,
		OP_FIND_LABEL = 3'd4
	} frt_op_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_BAD_LABEL = 3'd2,
		ST_ZERO_SIZE = 3'd3,
		ST_BOUNDS = 3'd4,
		ST_DUPLICATE = 3'd5,
		ST_OVERLAP = 3'd6,
		ST_FULL = 3'd7
	} frt_status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_COMMIT
	} frt_state_t;

	typedef struct packed {
		logic [31:0] offset;
		logic [31:0] size;
		logic [7:0] kind;
		logic [7:0] subkind;
		logic [31:0] flags;
		logic [63:0] label_low;
		logic [63:0] label_high;
	} frt_entry_t;

	typedef struct packed {
		logic [2:0] operation;
		logic [31:0] lookup_address;
		logic subkind_any;
		frt_entry_t entry;
	} frt_req_t;

	typedef struct packed {
		logic addr_hit;
		logic kind_hit;
		logic label_hit;
		logic overlap;
		logic less;
	} frt_match_t;

	typedef struct packed {
		logic capture;
		logic insert;
	} frt_cell_ctrl_t;

	function automatic logic char_ok(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h61 && c <= 8'h7A) || c == 8'h5F || c == 8'h2D;
	endfunction

	// A label is 1 to 15 legal characters followed only by zero bytes.
	function automatic logic label_ok(input logic [63:0] lo, input logic [63:0] hi);
		logic [127:0] w;
		logic [15:0] nz;
		logic ok;
		w = {hi, lo};
		ok = 1'b1;
		for (int i = 0; i < 16; i++) begin
			nz[i] = w[i*8 +: 8] != 8'h00;
			if (nz[i] && !char_ok(w[i*8 +: 8]))
				ok = 1'b0;
		end
		for (int i = 0; i < 15; i++) begin
			if (!nz[i] && nz[i+1])
				ok = 1'b0;
		end
		return ok && nz[0] && !nz[LABEL_MAX];
	endfunction

endpackage

// ===== hw/rtl/frt_cell.sv =====
`timescale 1ns / 1ps
module frt_cell (
	input  logic                  clk,
	input  frt_pkg::frt_cell_ctrl_t ctrl,
	input  frt_pkg::frt_req_t     req,
	input  logic                  valid,
	input  logic                  prev_ahead,
	input  frt_pkg::frt_entry_t   left_entry,
	output frt_pkg::frt_entry_t   entry,
	output frt_pkg::frt_match_t   hit,
	output logic                  ahead
);
	import frt_pkg::*;

	frt_entry_t entry_q;
	frt_match_t hit_q;
	frt_match_t hit_d;
	logic [32:0] own_start;
	logic [32:0] own_end;
	logic [32:0] new_start;
	logic [32:0] new_end;
	logic here;

	always_comb begin
		own_start = {1'b0, entry_q.offset};
		own_end = own_start + {1'b0, entry_q.size};
		new_start = {1'b0, req.entry.offset};
		new_end = new_start + {1'b0, req.entry.size};
		hit_d.addr_hit = valid && req.lookup_address >= entry_q.offset &&
			{1'b0, req.lookup_address} < own_end;
		hit_d.kind_hit = valid && entry_q.kind == req.entry.kind &&
			(req.subkind_any || entry_q.subkind == req.entry.subkind);
		hit_d.label_hit = valid && entry_q.label_low == req.entry.label_low &&
			entry_q.label_high == req.entry.label_high;
		hit_d.overlap = valid && !(own_end <= new_start || new_end <= own_start);
		hit_d.less = valid && entry_q.offset < req.entry.offset;
	end

	// Entries are sorted, so the cells before the new one form a prefix.
	assign ahead = hit_q.less;
	assign here = !ahead && prev_ahead;

	always_ff @(posedge clk) begin
		if (ctrl.capture)
			hit_q <= hit_d;
		if (ctrl.insert) begin
			if (here)
				entry_q <= req.entry;
			else if (!ahead)
				entry_q <= left_entry;
		end
	end

	assign entry = entry_q;
	assign hit = hit_q;

endmodule

// ===== hw/rtl/flash_region_table.sv =====
`timescale 1ns / 1ps
// Flash region table: up to sixteen regions kept sorted by start offset.
// Requests arrive on the in channel (in_valid / in_ready) with an operation
// code and its arguments; each request gives exactly one result on the out
// channel (out_valid / out_ready): a status, the matched entry and the
// number of entries afterwards. The flash limit is written through the cfg
// channel; the user must do so only while no request is outstanding, as the
// block itself does not enforce it. Each entry lives in one cell of a row;
// on an add every cell after the insertion point takes the entry of its left
// neighbour. After a request is accepted, every cell compares the registered
// request against its entry in S_EXEC; in S_COMMIT the first match is picked
// and the result committed. A new request is taken only in S_IDLE, after the
// previous commit, so no request is taken while another is in flight.
// Reset empties the table and restores the limit to 16 MiB. When the
// receiver stalls, the finished result waits in the output register; the
// block may still take and evaluate the next request but holds its commit
// until the output register is free.
module flash_region_table (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [2:0]   operation,
	input  logic [31:0]  region_offset,
	input  logic [31:0]  region_size,
	input  logic [31:0]  region_flags,
	input  logic [7:0]   kind,
	input  logic [7:0]   subkind,
	input  logic         subkind_any,
	input  logic [31:0]  lookup_address,
	input  logic [63:0]  label_low,
	input  logic [63:0]  label_high,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [2:0]   status,
	output logic [31:0]  found_offset,
	output logic [31:0]  found_size,
	output logic [7:0]   found_kind,
	output logic [7:0]   found_subkind,
	output logic [31:0]  found_flags,
	output logic [63:0]  found_label_low,
	output logic [63:0]  found_label_high,
	output logic [4:0]   entry_total,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [32:0]  cfg_data
);
	import frt_pkg::*;
	`include "flash_region_table_assert.svh"

	frt_state_t state_q, state_d;
	frt_req_t req_q;
	logic [32:0] limit_q;
	logic [CNT_W-1:0] count_q;
	logic label_ok_q, zero_q, bounds_q;

	frt_entry_t out_entry_q;
	logic [2:0] out_status_q;
	logic [CNT_W-1:0] out_total_q;
	logic out_valid_q;

	frt_cell_ctrl_t ctrl;
	frt_entry_t cell_entry [MAX_REGIONS];
	frt_match_t cell_hit [MAX_REGIONS];
	logic [MAX_REGIONS-1:0] cell_ahead;
	logic [MAX_REGIONS-1:0] cell_valid;

	logic commit;
	logic [MAX_REGIONS-1:0] sel_vec;
	logic [MAX_REGIONS-1:0] dup_vec, ovl_vec;
	frt_entry_t sel_entry;
	logic sel_found;
	logic [2:0] res_status;
	frt_entry_t res_entry;
	logic [CNT_W-1:0] res_count;
	logic add_ok;

	// The row of cells; cell 0 always sees an empty prefix before it.
	for (genvar g = 0; g < MAX_REGIONS; g++) begin : g_cell
		assign cell_valid[g] = count_q > CNT_W'(g);
		frt_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.req         (req_q),
			.valid       (cell_valid[g]),
			.prev_ahead  (g == 0 ? 1'b1 : cell_ahead[(g == 0) ? 0 : g-1]),
			.left_entry  (g == 0 ? req_q.entry : cell_entry[(g == 0) ? 0 : g-1]),
			.entry       (cell_entry[g]),
			.hit         (cell_hit[g]),
			.ahead       (cell_ahead[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		commit = 1'b0;
		ctrl = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid)
					state_d = S_EXEC;
			end
			S_EXEC: begin
				ctrl.capture = 1'b1;
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				if (!out_valid_q || out_ready) begin
					commit = 1'b1;
					ctrl.insert = add_ok;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Pick the lowest matching cell and work out the status.
	always_comb begin
		for (int i = 0; i < MAX_REGIONS; i++) begin
			dup_vec[i] = cell_hit[i].label_hit;
			ovl_vec[i] = cell_hit[i].overlap;
			unique case (req_q.operation)
				OP_FIND_ADDR:  sel_vec[i] = cell_hit[i].addr_hit;
				OP_FIND_KIND:  sel_vec[i] = cell_hit[i].kind_hit;
				OP_FIND_LABEL: sel_vec[i] = cell_hit[i].label_hit;
				default:       sel_vec[i] = 1'b0;
			endcase
		end
		sel_entry = '0;
		for (int i = MAX_REGIONS - 1; i >= 0; i--) begin
			if (sel_vec[i])
				sel_entry = cell_entry[i];
		end
		sel_found = |sel_vec;

		add_ok = 1'b0;
		res_entry = '0;
		res_count = count_q;
		res_status = ST_NOT_FOUND;
		unique case (req_q.operation)
			OP_CLEAR: begin
				res_status = ST_OK;
				res_count = '0;
			end
			OP_ADD: begin
				priority if (!label_ok_q)
					res_status = ST_BAD_LABEL;
				else if (zero_q)
					res_status = ST_ZERO_SIZE;
				else if (bounds_q)
					res_status = ST_BOUNDS;
				else if (|dup_vec)
					res_status = ST_DUPLICATE;
				else if (|ovl_vec)
					res_status = ST_OVERLAP;
				else if (count_q >= CNT_W'(MAX_REGIONS))
					res_status = ST_FULL;
				else begin
					res_status = ST_OK;
					add_ok = 1'b1;
					res_entry = req_q.entry;
					res_count = count_q + 1'b1;
				end
			end
			OP_FIND_ADDR, OP_FIND_KIND, OP_FIND_LABEL: begin
				if (sel_found) begin
					res_status = ST_OK;
					res_entry = sel_entry;
				end
			end
			default: res_status = ST_NOT_FOUND;
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_q.operation <= operation;
			req_q.lookup_address <= lookup_address;
			req_q.subkind_any <= subkind_any;
			req_q.entry <= '{offset: region_offset, size: region_size, kind: kind,
				subkind: subkind, flags: region_flags, label_low: label_low,
				label_high: label_high};
		end
		if (ctrl.capture) begin
			label_ok_q <= label_ok(req_q.entry.label_low, req_q.entry.label_high);
			zero_q <= req_q.entry.size == 32'd0;
			bounds_q <= ({1'b0, req_q.entry.offset} + {1'b0, req_q.entry.size}) > limit_q;
		end
		if (commit) begin
			out_entry_q <= res_entry;
			out_status_q <= res_status;
			out_total_q <= res_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			limit_q <= LIMIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				limit_q <= cfg_data;
			if (commit) begin
				count_q <= res_count;
				out_valid_q <= 1'b1;
			end else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign status = out_status_q;
	assign found_offset = out_entry_q.offset;
	assign found_size = out_entry_q.size;
	assign found_kind = out_entry_q.kind;
	assign found_subkind = out_entry_q.subkind;
	assign found_flags = out_entry_q.flags;
	assign found_label_low = out_entry_q.label_low;
	assign found_label_high = out_entry_q.label_high;
	assign entry_total = 5'(out_total_q);

	`FRT_ASSERT_SAME(a_count_max, 1'b1, count_q <= CNT_W'(MAX_REGIONS), "table count above capacity")
	`FRT_ASSERT_NEXT(a_add_grows, commit && add_ok, count_q == $past(count_q) + 1'b1, "add did not grow table")
	`FRT_ASSERT_NEXT(a_clear_empties, commit && req_q.operation == OP_CLEAR, count_q == '0, "clear left entries")
	`FRT_ASSERT_SAME(a_insert_free, ctrl.insert, commit && count_q < CNT_W'(MAX_REGIONS), "insert into full table")

endmodule
